// ===== hw/rtl/shem_pkg.sv =====
package shem_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 9;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_DATA_W = 13;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(256);
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(256);

   // channel 0 = red, 1 = green, 2 = blue
   typedef logic [2:0][7:0] pixel_type;
   // row 0 = two rows above, row 2 = current row
   typedef pixel_type [2:0] column_type;

   typedef struct packed {
      logic       op;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_item_type;

   typedef struct packed {
      logic [7:0] edge_red;
      logic [7:0] edge_green;
      logic [7:0] edge_blue;
      logic       last_of_frame;
   } rsp_item_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      pixel_type         data;
   } lb_write_type;

   function automatic logic [7:0] edge_mag(input logic [7:0] l0, input logic [7:0] l1,
                                           input logic [7:0] l2, input logic [7:0] r0,
                                           input logic [7:0] r1, input logic [7:0] r2);
      logic signed [10:0] g;
      logic [10:0]        mag;
      g = $signed({3'b000, r0}) - $signed({3'b000, l0})
        + $signed({2'b00, r1, 1'b0}) - $signed({2'b00, l1, 1'b0})
        + $signed({3'b000, r2}) - $signed({3'b000, l2});
      mag = g[10] ? 11'(-g) : 11'(g);
      return (mag > 11'd255) ? 8'hFF : mag[7:0];
   endfunction

endpackage

// ===== hw/rtl/sobel_horizontal_edge_magnitude_core.sv =====
// A result passes the stage 1 and output registers after the item that completes its
// window is accepted, one row plus one pixel behind the input stream. Throughput is 1
// item per cycle unless stalled, set by one line buffer read and one write per item.
// Reset: synchronous, active high; clears position counters, window and handshake state.
// Line buffer contents are not cleared; rows above the image are masked.
module sobel_horizontal_edge_magnitude_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  shem_pkg::req_item_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output shem_pkg::rsp_item_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [shem_pkg::CSR_DATA_W-1:0]    csr_data
);
   import shem_pkg::*;

   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic [WIDTH_W-1:0]  eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic                csr_write;
   logic                restart;

   logic [ADDR_W-1:0]   in_column_ff;
   logic [HEIGHT_W-1:0] in_row_ff;
   logic [WIDTH_W-1:0]  col_next;

   logic                accept;
   logic                advance;
   pixel_type           pix_in;
   logic                emit_in;
   logic                last_in;

   logic                s1_valid_ff;
   pixel_type           s1_pix_ff;
   logic [ADDR_W-1:0]   s1_col_ff;
   logic                s1_row_ge1_ff;
   logic                s1_row_ge2_ff;
   logic                s1_col0_ff;
   logic                s1_col1_ff;
   logic                s1_emit_ff;
   logic                s1_last_ff;

   pixel_type           above_q;
   pixel_type           two_above_q;
   lb_write_type        lb_wr;

   column_type          win0_ff;
   column_type          win1_ff;
   column_type          cur;
   column_type          left_col;
   column_type          right_col;

   logic                rsp_valid_ff;
   rsp_item_type        rsp_data_ff;
   rsp_item_type        rsp_data_in;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[WIDTH_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff < WIDTH_W'(MIN_DIM))        eff_w = WIDTH_W'(MIN_DIM);
      else if (frame_width_ff > WIDTH_W'(MAX_WIDTH)) eff_w = WIDTH_W'(MAX_WIDTH);
      else                                           eff_w = frame_width_ff;
      if (frame_height_ff < HEIGHT_W'(MIN_DIM))         eff_h = HEIGHT_W'(MIN_DIM);
      else if (frame_height_ff > HEIGHT_W'(MAX_HEIGHT)) eff_h = HEIGHT_W'(MAX_HEIGHT);
      else                                              eff_h = frame_height_ff;
   end

   // stage 0: position, pixel masking, line buffer read
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pix_in = '0;
      if (req_data.op == OP_PIXEL && in_row_ff < eff_h) begin
         pix_in = {req_data.blue, req_data.green, req_data.red};
      end
      emit_in = (in_row_ff >= HEIGHT_W'(2)) ||
                (in_row_ff == HEIGHT_W'(1) && in_column_ff != '0);
      last_in = (in_row_ff == HEIGHT_W'(eff_h + HEIGHT_W'(1))) && (in_column_ff == '0);
      col_next = WIDTH_W'({1'b0, in_column_ff} + WIDTH_W'(1));
   end

   assign restart = csr_write;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
      end else if (accept) begin
         if (last_in) begin
            in_column_ff <= '0;
            in_row_ff    <= '0;
         end else if (col_next >= eff_w) begin
            in_column_ff <= '0;
            in_row_ff    <= HEIGHT_W'(in_row_ff + HEIGHT_W'(1));
         end else begin
            in_column_ff <= col_next[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= pix_in;
         s1_col_ff     <= in_column_ff;
         s1_row_ge1_ff <= in_row_ff != '0;
         s1_row_ge2_ff <= in_row_ff >= HEIGHT_W'(2);
         s1_col0_ff    <= in_column_ff == '0;
         s1_col1_ff    <= in_column_ff == ADDR_W'(1);
         s1_emit_ff    <= emit_in;
         s1_last_ff    <= last_in;
      end
   end

   assign lb_wr.en   = advance;
   assign lb_wr.addr = s1_col_ff;
   assign lb_wr.data = s1_pix_ff;

   shem_line_buffer u_line_buffer (
      .clock       (clock),
      .rd_en       (accept),
      .rd_addr     (in_column_ff),
      .wr          (lb_wr),
      .above_q     (above_q),
      .two_above_q (two_above_q)
   );

   // stage 1: window and gradient
   always_comb begin
      cur[0] = s1_row_ge2_ff ? two_above_q : '0;
      cur[1] = s1_row_ge1_ff ? above_q : '0;
      cur[2] = s1_pix_ff;
      left_col  = s1_col1_ff ? '0 : win1_ff;
      right_col = s1_col0_ff ? '0 : cur;
      rsp_data_in.edge_red   = edge_mag(left_col[0][0], left_col[1][0], left_col[2][0],
                                        right_col[0][0], right_col[1][0], right_col[2][0]);
      rsp_data_in.edge_green = edge_mag(left_col[0][1], left_col[1][1], left_col[2][1],
                                        right_col[0][1], right_col[1][1], right_col[2][1]);
      rsp_data_in.edge_blue  = edge_mag(left_col[0][2], left_col[1][2], left_col[2][2],
                                        right_col[0][2], right_col[1][2], right_col[2][2]);
      rsp_data_in.last_of_frame = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         win0_ff <= '0;
         win1_ff <= '0;
      end else if (advance) begin
         if (s1_last_ff) begin
            win0_ff <= '0;
            win1_ff <= '0;
         end else begin
            win0_ff <= cur;
            win1_ff <= win0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_emit_ff;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_emit_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/shem_line_buffer.sv =====
module shem_line_buffer (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [shem_pkg::ADDR_W-1:0]   rd_addr,
   input  shem_pkg::lb_write_type        wr,
   output shem_pkg::pixel_type           above_q,
   output shem_pkg::pixel_type           two_above_q
);
   import shem_pkg::*;

   pixel_type mem_above     [MAX_WIDTH];
   pixel_type mem_two_above [MAX_WIDTH];
   pixel_type above_q_ff;
   pixel_type two_above_q_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         above_q_ff     <= mem_above[rd_addr];
         two_above_q_ff <= mem_two_above[rd_addr];
      end
   end

   // the row shifts down: the entry just read moves to the older line
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_above[wr.addr]     <= wr.data;
         mem_two_above[wr.addr] <= above_q_ff;
      end
   end

   assign above_q     = above_q_ff;
   assign two_above_q = two_above_q_ff;

endmodule
